@@ hdl/ttb_pkg.sv @@
// Shared types and constants for the triangle tangent/binormal block.
// No dependencies; imported by every module of the block.
package ttb_pkg;

  localparam int POS_BITS   = 32;
  localparam int UV_BITS    = 16;
  localparam int DW         = POS_BITS + 1;
  localparam int UW         = UV_BITS + 1;
  localparam int PW         = DW + UW;
  localparam int ACC_W      = 64;
  localparam int LIM_BITS   = 38;
  localparam int NORM_BITS  = 30;
  localparam int Q_BITS     = 15;
  localparam int OUT_W      = 16;
  localparam int JOBQ_DEPTH = 2;

  typedef struct packed {
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic signed [POS_BITS-1:0] pos_z;
    logic signed [UV_BITS-1:0]  tex_u;
    logic signed [UV_BITS-1:0]  tex_v;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] tangent_x;
    logic signed [OUT_W-1:0] tangent_y;
    logic signed [OUT_W-1:0] tangent_z;
    logic signed [OUT_W-1:0] binormal_x;
    logic signed [OUT_W-1:0] binormal_y;
    logic signed [OUT_W-1:0] binormal_z;
    logic                    tangent_zero;
    logic                    binormal_zero;
  } out_word_t;

  typedef struct packed {
    logic [2:0][DW-1:0] dp1;
    logic [2:0][DW-1:0] dp2;
    logic [UW-1:0]      du1;
    logic [UW-1:0]      dv1;
    logic [UW-1:0]      du2;
    logic [UW-1:0]      dv2;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jobq_stat_t;

endpackage

@@ hdl/ttb_front.sv @@
// Front end: holds the first two corners and forms the deltas on the third.
// Depends on ttb_pkg.
module ttb_front
  import ttb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  in_word_t   in_word,
  input  jobq_stat_t q_stat,
  output logic       job_push,
  output job_t       job
);

  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;

  logic [1:0]                 corner_r;
  logic signed [POS_BITS-1:0] pos0_r [3];
  logic signed [POS_BITS-1:0] pos1_r [3];
  logic signed [UV_BITS-1:0]  uv0_r  [2];
  logic signed [UV_BITS-1:0]  uv1_r  [2];
  logic signed [POS_BITS-1:0] cur    [3];
  logic                       accept;

  assign cur[0]   = in_word.pos_x;
  assign cur[1]   = in_word.pos_y;
  assign cur[2]   = in_word.pos_z;
  assign full     = (corner_r == CORNER_C) && q_stat.full;
  assign accept   = push && !full;
  assign job_push = accept && (corner_r == CORNER_C);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      job.dp1[k] = DW'(pos1_r[k]) - DW'(pos0_r[k]);
      job.dp2[k] = DW'(cur[k]) - DW'(pos0_r[k]);
    end
    job.du1 = UW'(uv1_r[0]) - UW'(uv0_r[0]);
    job.dv1 = UW'(uv1_r[1]) - UW'(uv0_r[1]);
    job.du2 = UW'(in_word.tex_u) - UW'(uv0_r[0]);
    job.dv2 = UW'(in_word.tex_v) - UW'(uv0_r[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r <= CORNER_A;
    end else if (accept) begin
      case (corner_r)
        CORNER_B: begin
          for (int k = 0; k < 3; k++) pos1_r[k] <= cur[k];
          uv1_r[0] <= in_word.tex_u;
          uv1_r[1] <= in_word.tex_v;
          corner_r <= CORNER_C;
        end
        CORNER_C: begin
          corner_r <= CORNER_A;
        end
        default: begin
          for (int k = 0; k < 3; k++) pos0_r[k] <= cur[k];
          uv0_r[0] <= in_word.tex_u;
          uv0_r[1] <= in_word.tex_v;
          corner_r <= CORNER_B;
        end
      endcase
    end
  end

endmodule

@@ hdl/ttb_jobq.sv @@
// Short job queue between front and back ends.
// Depends on ttb_pkg.
module ttb_jobq
  import ttb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       push_job,
  input  logic       pop,
  output job_t       pop_job,
  output jobq_stat_t stat
);

  localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

  job_t             mem_r [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(JOBQ_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_job    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ hdl/ttb_back.sv @@
// Back end: cross products, normalization by bit-serial root and divide.
// Depends on ttb_pkg; fed by ttb_jobq.
module ttb_back
  import ttb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  jobq_stat_t q_stat,
  input  job_t       job,
  output logic       job_pop,
  input  logic       pop,
  output logic       empty,
  output out_word_t  out_word
);

  localparam int RW        = NORM_BITS + Q_BITS;
  localparam int B_W       = $clog2(Q_BITS);
  localparam logic [2:0] MUL_STEPS = 3'd6;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SHRINK = 10'b0000000010,
    S_MUL    = 10'b0000000100,
    S_NSEL   = 10'b0000001000,
    S_NSHIFT = 10'b0000010000,
    S_SQ     = 10'b0000100000,
    S_SQRT   = 10'b0001000000,
    S_DLOAD  = 10'b0010000000,
    S_DIV    = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic signed [DW-1:0]    dp1_r [3], dp2_r [3];
  logic signed [UW-1:0]    du1_r, dv1_r, du2_r, dv2_r;
  logic [2:0]              cnt_r, pidx_r;
  logic                    pvld_r;
  logic signed [PW-1:0]    ptan_r, pbin_r;
  logic signed [ACC_W-1:0] tan_r [3], bin_r [3];
  logic                    vsel_r;
  logic [ACC_W-1:0]        m_r [3];
  logic [2:0]              neg_r;
  logic [ACC_W-1:0]        sum_r, x_r, root_r, bit_r;
  logic [31:0]             len_r;
  logic [RW-1:0]           rem_r;
  logic [B_W-1:0]          b_r;
  logic [Q_BITS-1:0]       q_r;
  logic [1:0]              comp_r;
  logic [OUT_W-1:0]        tvec_r [3], bvec_r [3];
  logic                    tzero_r, bzero_r;
  logic                    out_valid_r;
  out_word_t               out_word_r;

  function automatic logic [DW-1:0] dmag(input logic signed [DW-1:0] x);
    return x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

  function automatic logic signed [DW-1:0] shr_tz(input logic signed [DW-1:0] x);
    logic [DW-1:0] m;
    m = dmag(x) >> 1;
    return x[DW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [ACC_W-1:0] amag(input logic signed [ACC_W-1:0] x);
    return x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
  endfunction

  logic [DW-1:0]           dbig;
  logic                    shrink_need;
  logic [1:0]              mi;
  logic                    mt;
  logic signed [DW-1:0]    ma_t, ma_b;
  logic signed [UW-1:0]    mb_t, mb_b;
  logic signed [ACC_W-1:0] cvec [3];
  logic                    czero;
  logic [ACC_W-1:0]        nbig;
  logic                    too_big, too_small;
  logic [NORM_BITS-1:0]    sq_op;
  logic [2*NORM_BITS-1:0]  sq;
  logic [ACC_W-1:0]        sum_nxt, trial, root_nxt;
  logic                    sge;
  logic [RW-1:0]           dtrial;
  logic                    dge;
  logic [Q_BITS-1:0]       q_nxt;
  logic [OUT_W-1:0]        res;

  always_comb begin
    dbig = '0;
    for (int k = 0; k < 3; k++) dbig = dbig | dmag(dp1_r[k]) | dmag(dp2_r[k]);
  end
  assign shrink_need = (dbig >> LIM_BITS) != '0;

  assign mi   = cnt_r[2:1];
  assign mt   = cnt_r[0];
  assign ma_t = mt ? dp2_r[mi] : dp1_r[mi];
  assign mb_t = mt ? dv1_r : dv2_r;
  assign ma_b = mt ? dp1_r[mi] : dp2_r[mi];
  assign mb_b = mt ? du2_r : du1_r;

  always_comb begin
    for (int k = 0; k < 3; k++) cvec[k] = vsel_r ? bin_r[k] : tan_r[k];
  end
  assign czero     = (cvec[0] == '0) && (cvec[1] == '0) && (cvec[2] == '0);
  assign nbig      = m_r[0] | m_r[1] | m_r[2];
  assign too_big   = (nbig >> NORM_BITS) != '0;
  assign too_small = !nbig[NORM_BITS-1];

  assign sq_op   = m_r[cnt_r[1:0]][NORM_BITS-1:0];
  assign sq      = sq_op * sq_op;
  assign sum_nxt = sum_r + ACC_W'(sq);

  assign trial    = root_r + bit_r;
  assign sge      = x_r >= trial;
  assign root_nxt = sge ? (root_r >> 1) + bit_r : root_r >> 1;

  assign dtrial = RW'(len_r) << b_r;
  assign dge    = rem_r >= dtrial;
  assign q_nxt  = dge ? (q_r | (Q_BITS'(1) << b_r)) : q_r;
  assign res    = neg_r[comp_r] ? OUT_W'(-OUT_W'(q_nxt)) : OUT_W'(q_nxt);

  assign job_pop  = (state_r == S_IDLE) && !q_stat.empty;
  assign empty    = !out_valid_r;
  assign out_word = out_word_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (!q_stat.empty) state_nxt = S_SHRINK;
      S_SHRINK: if (!shrink_need) state_nxt = S_MUL;
      S_MUL:    if (cnt_r == MUL_STEPS) state_nxt = S_NSEL;
      S_NSEL: begin
        if (!czero)     state_nxt = S_NSHIFT;
        else if (vsel_r) state_nxt = S_OUT;
      end
      S_NSHIFT: if (!too_big && !too_small) state_nxt = S_SQ;
      S_SQ:     if (cnt_r == 3'd2) state_nxt = S_SQRT;
      S_SQRT:   if (bit_r == ACC_W'(1)) state_nxt = S_DLOAD;
      S_DLOAD:  state_nxt = S_DIV;
      S_DIV: begin
        if (b_r == '0) begin
          if (comp_r != 2'd2) state_nxt = S_DLOAD;
          else if (vsel_r)    state_nxt = S_OUT;
          else                state_nxt = S_NSEL;
        end
      end
      S_OUT:    if (!out_valid_r || pop) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pvld_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pvld_r  <= (state_r == S_MUL) && (cnt_r < MUL_STEPS);
      if (state_r == S_OUT && (!out_valid_r || pop)) out_valid_r <= 1'b1;
      else if (pop)                                  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= (state_nxt != state_r) ? '0 : cnt_r + 1'b1;
    pidx_r <= cnt_r;
    ptan_r <= ma_t * mb_t;
    pbin_r <= ma_b * mb_b;
    if (pvld_r) begin
      if (!pidx_r[0]) begin
        tan_r[pidx_r[2:1]] <= ACC_W'(ptan_r);
        bin_r[pidx_r[2:1]] <= ACC_W'(pbin_r);
      end else begin
        tan_r[pidx_r[2:1]] <= tan_r[pidx_r[2:1]] - ACC_W'(ptan_r);
        bin_r[pidx_r[2:1]] <= bin_r[pidx_r[2:1]] - ACC_W'(pbin_r);
      end
    end
    unique case (state_r)
      S_IDLE: begin
        for (int k = 0; k < 3; k++) begin
          dp1_r[k] <= $signed(job.dp1[k]);
          dp2_r[k] <= $signed(job.dp2[k]);
        end
        du1_r  <= $signed(job.du1);
        dv1_r  <= $signed(job.dv1);
        du2_r  <= $signed(job.du2);
        dv2_r  <= $signed(job.dv2);
        vsel_r <= 1'b0;
      end
      S_SHRINK: begin
        if (shrink_need) begin
          for (int k = 0; k < 3; k++) begin
            dp1_r[k] <= shr_tz(dp1_r[k]);
            dp2_r[k] <= shr_tz(dp2_r[k]);
          end
        end
      end
      S_NSEL: begin
        for (int k = 0; k < 3; k++) begin
          m_r[k]   <= amag(cvec[k]);
          neg_r[k] <= cvec[k][ACC_W-1];
        end
        sum_r  <= '0;
        comp_r <= 2'd0;
        if (vsel_r) bzero_r <= czero;
        else        tzero_r <= czero;
        if (czero) begin
          for (int k = 0; k < 3; k++) begin
            if (vsel_r) bvec_r[k] <= '0;
            else        tvec_r[k] <= '0;
          end
          vsel_r <= 1'b1;
        end
      end
      S_NSHIFT: begin
        for (int k = 0; k < 3; k++) begin
          if (too_big)        m_r[k] <= m_r[k] >> 1;
          else if (too_small) m_r[k] <= m_r[k] << 1;
        end
      end
      S_SQ: begin
        sum_r  <= sum_nxt;
        x_r    <= sum_nxt;
        root_r <= '0;
        bit_r  <= ACC_W'(1) << (ACC_W - 2);
      end
      S_SQRT: begin
        if (sge) x_r <= x_r - trial;
        root_r <= root_nxt;
        bit_r  <= bit_r >> 2;
        len_r  <= root_nxt[31:0];
      end
      S_DLOAD: begin
        rem_r <= (RW'(m_r[comp_r][NORM_BITS-1:0]) << (Q_BITS - 1)) + RW'(len_r >> 1);
        b_r   <= B_W'(Q_BITS - 1);
        q_r   <= '0;
      end
      S_DIV: begin
        if (dge) rem_r <= rem_r - dtrial;
        q_r <= q_nxt;
        b_r <= b_r - 1'b1;
        if (b_r == '0) begin
          if (vsel_r) bvec_r[comp_r] <= res;
          else        tvec_r[comp_r] <= res;
          comp_r <= comp_r + 1'b1;
          if (comp_r == 2'd2) vsel_r <= 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || pop) begin
          out_word_r.tangent_x     <= tvec_r[0];
          out_word_r.tangent_y     <= tvec_r[1];
          out_word_r.tangent_z     <= tvec_r[2];
          out_word_r.binormal_x    <= bvec_r[0];
          out_word_r.binormal_y    <= bvec_r[1];
          out_word_r.binormal_z    <= bvec_r[2];
          out_word_r.tangent_zero  <= tzero_r;
          out_word_r.binormal_zero <= bzero_r;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |-> (!too_big && !too_small))
    else $error("magnitudes not normalized before squaring");
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (len_r != '0))
    else $error("divide by zero length");
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && b_r == '0) |-> (q_nxt <= Q_BITS'(16384)))
    else $error("quotient above unit");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || pop)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result word not loaded");
`endif

endmodule

@@ hdl/triangle_tangent_binormal_top.sv @@
// Top level of the triangle tangent/binormal block.
// Depends on ttb_pkg, ttb_front, ttb_jobq and ttb_back.
//
// Usage: vertices enter as in_word with push; a word is taken on a rising
// edge with push high and full low. Every third vertex closes a triangle and
// yields one result word: Q1.14 unit tangent and binormal plus zero flags.
// Results leave as out_word; it is valid while empty is low and is taken on a
// rising edge with pop high. The first two corners never block; the third
// blocks only while the two-entry job queue is full.
// With an idle back end, the time from the third corner to its result when
// both vectors are nonzero is set by the bit-serial square root
// (32 steps) and the restoring divide (15 steps plus one load per component)
// of each vector, plus the normalizing shift of up to 29 steps. Zero-length
// vectors skip root and divide.
// Throughput is one triangle per back-end pass, the front end running ahead.
// Reset (rst_n low at a clock edge) restarts at corner zero and drops all
// queued and pending work. While pop stays low the result word holds; the
// back end finishes the next triangle and waits, then the queue fills and
// full rises on a third corner.
module triangle_tangent_binormal_top
  import ttb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word
);

  jobq_stat_t q_stat;
  job_t       push_job, pop_job;
  logic       job_push, job_pop;

  ttb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .q_stat   (q_stat),
    .job_push (job_push),
    .job      (push_job)
  );

  ttb_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  ttb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .job      (pop_job),
    .job_pop  (job_pop),
    .pop      (pop),
    .empty    (empty),
    .out_word (out_word)
  );

endmodule

@@ dv/testbench.sv @@
// Testbench for triangle_tangent_binormal_top: vertex words in, tangent/binormal words out.
// Depends on ttb_pkg and the block RTL; predicts each triangle result and compares the whole word.
`timescale 1ns / 1ps

module testbench;
  import ttb_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_word_t  in_word;
  logic      empty;
  logic      pop;
  out_word_t out_word;

  triangle_tangent_binormal_top u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
    .empty(empty), .pop(pop), .out_word(out_word)
  );

  in_word_t  vertex_q[$];
  out_word_t tbn_q[$];
  int        send_idle_pct;
  int        recv_stall_pct;
  int        mismatches;
  int        cycles;
  bit        done;
  bit        in_taken;

  logic [1:0]               corner;
  logic signed [63:0]       hold_p[6];
  logic signed [63:0]       hold_t[4];

  initial begin
    clk = 1'b0;
  end
  always #6 clk = ~clk;

  function automatic logic [63:0] mag64(logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  function automatic int bitlen(logic [63:0] x);
    int n;
    n = 0;
    while (x != 0) begin
      n++;
      x = x >> 1;
    end
    return n;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic unit_vector(input logic signed [63:0] c[3], output logic [15:0] o[3],
                             output logic zero);
    logic [63:0] m[3];
    logic [63:0] big;
    logic [63:0] len;
    logic [63:0] q;
    int n;
    big = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag64(c[i]);
      if (m[i] > big) big = m[i];
    end
    zero = (big == 0);
    if (zero) begin
      for (int i = 0; i < 3; i++) o[i] = 16'd0;
    end else begin
      n = bitlen(big);
      for (int i = 0; i < 3; i++)
        m[i] = n > NORM_BITS ? m[i] >> (n - NORM_BITS) : m[i] << (NORM_BITS - n);
      len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * 64'd16384 + (len >> 1)) / len;
        o[i] = c[i] < 0 ? 16'(-q) : 16'(q);
      end
    end
  endtask

  task automatic predict_vertex(input in_word_t w);
    logic signed [63:0] p[3];
    logic signed [63:0] d1[3];
    logic signed [63:0] d2[3];
    logic signed [63:0] tg[3];
    logic signed [63:0] bn[3];
    logic signed [63:0] du1, dv1, du2, dv2, tu, tv;
    logic [63:0] big;
    logic [15:0] ot[3];
    logic [15:0] ob[3];
    logic zt, zb;
    int n;
    out_word_t r;
    p[0] = 64'(w.pos_x);
    p[1] = 64'(w.pos_y);
    p[2] = 64'(w.pos_z);
    tu = 64'(w.tex_u);
    tv = 64'(w.tex_v);
    if (corner == 2'd0 || corner == 2'd3) begin
      for (int i = 0; i < 3; i++) hold_p[i] = p[i];
      hold_t[0] = tu;
      hold_t[1] = tv;
      corner = 2'd1;
    end else if (corner == 2'd1) begin
      for (int i = 0; i < 3; i++) hold_p[3 + i] = p[i];
      hold_t[2] = tu;
      hold_t[3] = tv;
      corner = 2'd2;
    end else begin
      corner = 2'd0;
      big = '0;
      for (int i = 0; i < 3; i++) begin
        d1[i] = hold_p[3 + i] - hold_p[i];
        d2[i] = p[i] - hold_p[i];
        if (mag64(d1[i]) > big) big = mag64(d1[i]);
        if (mag64(d2[i]) > big) big = mag64(d2[i]);
      end
      n = bitlen(big);
      if (n > LIM_BITS) begin
        for (int i = 0; i < 3; i++) begin
          d1[i] = d1[i] < 0 ? -(mag64(d1[i]) >> (n - LIM_BITS)) : d1[i] >>> (n - LIM_BITS);
          d2[i] = d2[i] < 0 ? -(mag64(d2[i]) >> (n - LIM_BITS)) : d2[i] >>> (n - LIM_BITS);
        end
      end
      du1 = hold_t[2] - hold_t[0];
      dv1 = hold_t[3] - hold_t[1];
      du2 = tu - hold_t[0];
      dv2 = tv - hold_t[1];
      for (int i = 0; i < 3; i++) begin
        tg[i] = d1[i] * dv2 - d2[i] * dv1;
        bn[i] = d2[i] * du1 - d1[i] * du2;
      end
      unit_vector(tg, ot, zt);
      unit_vector(bn, ob, zb);
      r.tangent_x = ot[0];
      r.tangent_y = ot[1];
      r.tangent_z = ot[2];
      r.binormal_x = ob[0];
      r.binormal_y = ob[1];
      r.binormal_z = ob[2];
      r.tangent_zero = zt;
      r.binormal_zero = zb;
      tbn_q = {tbn_q, r};
    end
  endtask

  task automatic queue_vertex(input in_word_t w);
    vertex_q = {vertex_q, w};
  endtask

  function automatic in_word_t rand_vertex(int mode);
    in_word_t w;
    w.pos_x = 32'($urandom);
    w.pos_y = 32'($urandom);
    w.pos_z = 32'($urandom);
    w.tex_u = 16'($urandom);
    w.tex_v = 16'($urandom);
    if (mode == 1) begin
      w.pos_x = 32'($signed(16'($urandom))) <<< $urandom_range(0, 15);
      w.pos_y = 32'($signed(16'($urandom))) <<< $urandom_range(0, 15);
      w.pos_z = 32'($signed(16'($urandom))) <<< $urandom_range(0, 15);
      w.tex_u = 16'($signed(12'($urandom))) <<< $urandom_range(0, 4);
      w.tex_v = 16'($signed(12'($urandom))) <<< $urandom_range(0, 4);
    end else if (mode == 2) begin
      w.pos_x = 32'($signed(6'($urandom)));
      w.pos_y = 32'($signed(6'($urandom)));
      w.pos_z = 32'($signed(6'($urandom)));
      w.tex_u = 16'($signed(3'($urandom)));
      w.tex_v = 16'($signed(3'($urandom)));
    end
    return w;
  endfunction

  function automatic in_word_t make_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                           logic [15:0] u, logic [15:0] v);
    in_word_t w;
    w.pos_x = x;
    w.pos_y = y;
    w.pos_z = z;
    w.tex_u = u;
    w.tex_v = v;
    return w;
  endfunction

  task automatic wait_drained();
    while (vertex_q.size() != 0 || push || tbn_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    in_taken = rst_n && push && !full;
    if (in_taken) predict_vertex(in_word);
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (vertex_q.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
        in_word <= vertex_q.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
    pop <= rst_n && ($urandom_range(1, 100) > recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (tbn_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word %h", out_word);
      end else if (out_word !== tbn_q[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result mismatch expected %p actual %p", tbn_q[0], out_word);
        void'(tbn_q.pop_front());
      end else begin
        void'(tbn_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!done && cycles > 3000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_word = '0;
    corner = 2'd0;
    mismatches = 0;
    cycles = 0;
    done = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    phase_idle = '{0, 83, 0, 15};
    phase_stall = '{0, 0, 83, 15};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_vertex(make_vertex(32'h7fffffff, 32'h80000000, 32'h0, 16'h7fff, 16'h8000));
    queue_vertex(make_vertex(32'h80000000, 32'h7fffffff, 32'hffffffff, 16'h8000, 16'h7fff));
    queue_vertex(make_vertex(32'h0, 32'h0, 32'h7fffffff, 16'h0, 16'h0));
    queue_vertex(make_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
    queue_vertex(make_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
    queue_vertex(make_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
    queue_vertex(make_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
    queue_vertex(make_vertex(32'h10000, 32'h0, 32'h0, 16'h4000, 16'h0));
    queue_vertex(make_vertex(32'h0, 32'h10000, 32'h0, 16'h0, 16'h4000));
    queue_vertex(make_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
    queue_vertex(make_vertex(32'h10000, 32'h0, 32'h0, 16'h4000, 16'h0));
    queue_vertex(make_vertex(32'h20000, 32'h0, 32'h0, 16'h8000, 16'h0));
    queue_vertex(make_vertex(32'd5, 32'd0, 32'd0, 16'd1, 16'd0));
    queue_vertex(make_vertex(32'd5, 32'd1, 32'd0, 16'd1, 16'd1));
    queue_vertex(make_vertex(32'd5, 32'd0, 32'd1, 16'd2, 16'd1));
    queue_vertex(make_vertex(32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff));
    queue_vertex(make_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff));
    queue_vertex(make_vertex(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000));
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      for (int t = 0; t < 145; t++) begin
        int mode;
        mode = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) queue_vertex(rand_vertex(mode));
        if (t == 70) wait_drained();
        while (vertex_q.size() > 6) @(posedge clk);
      end
      wait_drained();
    end
    repeat (400) @(posedge clk);
    done = 1'b1;
    if (mismatches == 0 && tbn_q.size() == 0 && empty) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ttb_pkg.sv
hdl/ttb_front.sv
hdl/ttb_jobq.sv
hdl/ttb_back.sv
hdl/triangle_tangent_binormal_top.sv
dv/testbench.sv
